FILE: design/assert_macros.svh
// Assertion macros used by the top level of the decimal text converter.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cond_b holds in the same cycle in which cond_a holds.
`define ASSERT_IMPLY(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
    else $error(msg);

// Checks that cond_b holds in the cycle after one in which cond_a holds.
`define ASSERT_NEXT(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
    else $error(msg);

`endif

FILE: design/sidt_pkg.sv
// Package for the decimal text converter: widths, character codes and types.
// Depends on nothing.
package sidt_pkg;

  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 7;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int IDX_W      = $clog2(BCD_DIGITS);
  localparam int CNT_W      = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] MINUS_CODE   = 7'd45;
  localparam logic [CHAR_W-1:0] DIGIT_BASE   = 7'd48;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 7'd10;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: design/signed_int_to_decimal_text.sv
// Top level: signed 64-bit integer to decimal ASCII text, one character per word.
// Each value passes the 64 single-bit steps of the BCD shift register before its
// characters are emitted; the converter takes no new value until its newline has
// been emitted. Two queued words let the input run ahead of conversion. Reset
// (rst_n, synchronous) empties the queue and output.
module signed_int_to_decimal_text (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [sidt_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sidt_pkg::CHAR_W-1:0]        out_char_code,
  output logic                               out_last
);
  import sidt_pkg::*;
  `include "assert_macros.svh"

  logic       push_valid, push_ready;
  job_t       push_job;
  logic       pop_valid, pop_ready;
  job_t       pop_job;
  fifo_stat_t fifo_stat;

  sidt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  sidt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .stat       (fifo_stat)
  );

  sidt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_job       (pop_job),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  `ASSERT_IMPLY(a_fifo_state, fifo_stat.full, !fifo_stat.empty, "queue full and empty")
  `ASSERT_IMPLY(a_last_is_nl, out_valid && out_last, out_char_code == NEWLINE_CODE, "last not newline")
  `ASSERT_IMPLY(a_nl_is_last, out_valid && !out_last, out_char_code != NEWLINE_CODE, "newline not last")
  `ASSERT_NEXT(a_run_gapless, out_valid && out_ready && !out_last, out_valid, "gap inside a run")

endmodule

FILE: design/sidt_front.sv
// Front end: accepts one word, splits it into sign and unsigned magnitude.
// Depends on sidt_pkg.
module sidt_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [sidt_pkg::VALUE_W-1:0] in_value,
  output logic                               push_valid,
  input  logic                               push_ready,
  output sidt_pkg::job_t                     push_job
);
  import sidt_pkg::*;

  logic               vld_r, vld_nxt;
  job_t               job_r, job_nxt;
  logic [VALUE_W-1:0] raw;
  logic               take;

  assign raw        = in_value;
  assign in_ready   = !vld_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = vld_r;
  assign push_job   = job_r;

  always_comb begin
    vld_nxt = vld_r;
    job_nxt = job_r;
    if (push_ready) begin
      vld_nxt = 1'b0;
    end
    if (take) begin
      vld_nxt     = 1'b1;
      job_nxt.neg = raw[VALUE_W-1];
      job_nxt.mag = raw[VALUE_W-1] ? (~raw + {{(VALUE_W-1){1'b0}}, 1'b1}) : raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

FILE: design/sidt_fifo.sv
// Two-entry queue of classified words between the front and back ends.
// Depends on sidt_pkg.
module sidt_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  sidt_pkg::job_t       push_job,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output sidt_pkg::job_t       pop_job,
  output sidt_pkg::fifo_stat_t stat
);
  import sidt_pkg::*;

  job_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: design/sidt_back.sv
// Back end: shift-add-3 binary to BCD conversion, then character emission
// through an output register. Depends on sidt_pkg.
module sidt_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  sidt_pkg::job_t               pop_job,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sidt_pkg::CHAR_W-1:0]  out_char_code,
  output logic                         out_last
);
  import sidt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_DIG  = 3'd4;
  localparam logic [2:0] S_NL   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic               neg_r, neg_nxt;
  logic [VALUE_W-1:0] sh_r, sh_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [BCD_W-1:0]   adj;
  logic [IDX_W-1:0]   lead;
  logic [3:0]         dig;
  logic               can_emit;
  logic               emit;
  logic [CHAR_W-1:0]  emit_char;
  logic               emit_last;

  assign pop_ready     = (state_r == S_IDLE);
  assign can_emit      = !out_valid_r || out_ready;
  assign dig           = bcd_r[{idx_r, 2'b00} +: 4];
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  always_comb begin
    adj  = '0;
    lead = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? (bcd_r[i*4 +: 4] + 4'd3)
                                                : bcd_r[i*4 +: 4];
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    sh_nxt    = sh_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    emit      = 1'b0;
    emit_char = NEWLINE_CODE;
    emit_last = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          neg_nxt   = pop_job.neg;
          sh_nxt    = pop_job.mag;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        {bcd_nxt, sh_nxt} = {adj, sh_r} << 1;
        cnt_nxt = cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_nxt   = lead;
        state_nxt = neg_r ? S_SIGN : S_DIG;
      end
      S_SIGN: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = MINUS_CODE;
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = DIGIT_BASE + {3'b000, dig};
          if (idx_r == '0) begin
            state_nxt = S_NL;
          end else begin
            idx_nxt = idx_r - {{(IDX_W-1){1'b0}}, 1'b1};
          end
        end
      end
      S_NL: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = NEWLINE_CODE;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = emit || (out_valid_r && !out_ready);
    out_char_nxt  = emit ? emit_char : out_char_r;
    out_last_nxt  = emit ? emit_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    sh_r       <= sh_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
